@@ design/mcs_pkg.sv @@
// Shared types and constants of the masked contrast stretch block.
// Used by the front, queue and back modules; depends on nothing else.
package mcs_pkg;

    localparam int PIX_W   = 8;                 // grey level width
    localparam int MAG_W   = 2 * PIX_W;         // |numerator| width
    localparam int QUO_W   = MAG_W + 1;         // rounded quotient width
    localparam int VAL_W   = QUO_W + 2;         // signed sum before the clamp
    localparam int STEP_W  = $clog2(MAG_W);     // divider step counter width
    localparam int CFG_IDX_W = 1;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 1'b1;

    // One stretch job, fully prepared for the divider.
    typedef struct packed {
        logic             flat;      // brightest equals darkest
        logic [PIX_W-1:0] flat_val;  // result for a flat job
        logic             neg;       // sign of numerator over span
        logic [MAG_W-1:0] mag;       // |(p - darkest) * (out_max - out_min)|
        logic [PIX_W-1:0] den;       // |brightest - darkest|
        logic [PIX_W-1:0] out_min;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RND  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_back_state;

endpackage

@@ design/mcs_front.sv @@
// Front end: accepts pixel transactions, keeps the region statistics and
// the range registers, and prepares stretch jobs. Depends on mcs_pkg.
module mcs_front
    import mcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_in_region,
    input  logic                 i_restart,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_q_full,
    output t_push                o_push
);

    logic [PIX_W-1:0] r_out_min, r_out_max, r_dark, r_bright;
    logic [PIX_W-1:0] n_dark, n_bright;
    logic             w_accept;
    logic [PIX_W:0]   w_pd, w_sc, w_sp;
    logic [PIX_W-1:0] w_pd_abs, w_sc_abs, w_sp_abs;

    assign w_accept    = i_in_valid & ~i_q_full;
    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;

    // Measure pass: restart first, then fold in a pixel of the region.
    always_comb begin
        n_dark   = r_dark;
        n_bright = r_bright;
        if (w_accept && !i_mode) begin
            if (i_restart) begin
                n_dark   = PIX_MAX;
                n_bright = PIX_MIN;
            end
            if (i_in_region) begin
                if (i_pixel < n_dark) begin
                    n_dark = i_pixel;
                end
                if (i_pixel > n_bright) begin
                    n_bright = i_pixel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= PIX_MIN;
            r_out_max <= PIX_MAX;
            r_dark    <= PIX_MAX;
            r_bright  <= PIX_MIN;
        end else begin
            r_dark   <= n_dark;
            r_bright <= n_bright;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OUT_MIN: r_out_min <= i_cfg_data;
                    CFG_OUT_MAX: r_out_max <= i_cfg_data;
                    default:     r_out_min <= r_out_min;
                endcase
            end
        end
    end

    // Signed differences as sign and magnitude; the product sign is the
    // parity of the three signs, since the divisor is made positive.
    assign w_pd = {1'b0, i_pixel}   - {1'b0, r_dark};
    assign w_sc = {1'b0, r_out_max} - {1'b0, r_out_min};
    assign w_sp = {1'b0, r_bright}  - {1'b0, r_dark};

    assign w_pd_abs = w_pd[PIX_W] ? PIX_W'(-w_pd) : w_pd[PIX_W-1:0];
    assign w_sc_abs = w_sc[PIX_W] ? PIX_W'(-w_sc) : w_sc[PIX_W-1:0];
    assign w_sp_abs = w_sp[PIX_W] ? PIX_W'(-w_sp) : w_sp[PIX_W-1:0];

    always_comb begin
        o_push.valid        = w_accept & i_mode;
        o_push.job.flat     = (r_bright == r_dark);
        o_push.job.flat_val = (i_pixel > r_dark) ? PIX_MAX : PIX_MIN;
        o_push.job.neg      = w_pd[PIX_W] ^ w_sc[PIX_W] ^ w_sp[PIX_W];
        o_push.job.mag      = MAG_W'(w_pd_abs) * MAG_W'(w_sc_abs);
        o_push.job.den      = w_sp_abs;
        o_push.job.out_min  = r_out_min;
    end

endmodule

@@ design/mcs_queue.sv @@
// Short job queue between the front end and the divider back end.
// Depends on mcs_pkg for the job type.
module mcs_queue
    import mcs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_job  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr  = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_pop) begin
            n_rd  = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

endmodule

@@ design/mcs_back.sv @@
// Back end: restoring divider (one quotient bit per cycle), round half to
// even, offset, clamp and the output register. Depends on mcs_pkg.
module mcs_back
    import mcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_job             i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_stretched_pixel
);

    t_back_state             r_state, n_state;
    logic [STEP_W-1:0]       r_step;
    logic [PIX_W-1:0]        r_rem, r_den, r_omin, r_flat_val, r_out_pixel;
    logic [MAG_W-1:0]        r_quo;
    logic [QUO_W-1:0]        r_qr;
    logic                    r_neg, r_flat, r_out_valid;
    logic [PIX_W:0]          w_trial, w_sub, w_twice_r;
    logic                    w_ge, w_up, w_fin_ok;
    logic signed [VAL_W-1:0] w_sq, w_val;
    logic [PIX_W-1:0]        w_res;

    assign o_pop             = (r_state == ST_IDLE) & i_q_valid;
    assign o_out_valid       = r_out_valid;
    assign o_stretched_pixel = r_out_pixel;
    assign w_fin_ok          = ~r_out_valid | ~i_out_stall;

    // Divider step: shift in the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_sub   = w_trial - {1'b0, r_den};

    // Round half to even on the magnitude; the rule is symmetric in sign.
    assign w_twice_r = {r_rem, 1'b0};
    assign w_up = (w_twice_r > {1'b0, r_den}) ||
                  ((w_twice_r == {1'b0, r_den}) && r_quo[0]);

    assign w_sq  = r_neg ? -$signed({2'b00, r_qr}) : $signed({2'b00, r_qr});
    assign w_val = $signed({{(VAL_W - PIX_W){1'b0}}, r_omin}) + w_sq;

    always_comb begin
        if (r_flat) begin
            w_res = r_flat_val;
        end else if (w_val[VAL_W-1]) begin
            w_res = PIX_MIN;
        end else if (w_val[VAL_W-2:PIX_W] != '0) begin
            w_res = PIX_MAX;
        end else begin
            w_res = w_val[PIX_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) begin
                n_state = i_head.flat ? ST_FIN : ST_DIV;
            end
            ST_DIV: if (r_step == STEP_W'(MAG_W - 1)) begin
                n_state = ST_RND;
            end
            ST_RND: n_state = ST_FIN;
            ST_FIN: if (w_fin_ok) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FIN) && w_fin_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo      <= i_head.mag;
            r_rem      <= '0;
            r_den      <= i_head.den;
            r_neg      <= i_head.neg;
            r_omin     <= i_head.out_min;
            r_flat     <= i_head.flat;
            r_flat_val <= i_head.flat_val;
            r_step     <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo  <= {r_quo[MAG_W-2:0], w_ge};
            r_rem  <= w_ge ? w_sub[PIX_W-1:0] : w_trial[PIX_W-1:0];
            r_step <= r_step + 1'b1;
        end
        if (r_state == ST_RND) begin
            r_qr <= {1'b0, r_quo} + QUO_W'(w_up);
        end
        if ((r_state == ST_FIN) && w_fin_ok) begin
            r_out_pixel <= w_res;
        end
    end

endmodule

@@ design/masked_contrast_stretch.sv @@
// A stretch transaction passes from the front end into the queue, then through
// the bit-serial divider, rounding and the finish step into the output register;
// a flat job skips divider and rounding. The single divider works on one job at a
// time; measure transactions are taken one per cycle while the queue has room.
// Reset (synchronous, active low) empties the queue and output and restores
// out_min 0, out_max 255, darkest 255, brightest 0.
module masked_contrast_stretch
    import mcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_in_region,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_stretched_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    // The front end handles every input transaction in the cycle it is
    // accepted. Measure transactions only update the darkest and brightest
    // levels. Stretch transactions take a snapshot of the statistics and the
    // range registers, form the numerator and divisor as sign and magnitude,
    // and push the prepared job into the queue. The front stalls only when
    // the queue is full.
    t_push w_push;
    logic  w_q_full, w_q_valid, w_pop;
    t_job  w_head;

    mcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_pixel     (i_pixel),
        .i_in_region (i_in_region),
        .i_restart   (i_restart),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push)
    );

    // Jobs wait here so the front keeps taking transactions while the
    // divider is busy or the output is stalled.
    mcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // The back end divides the magnitude, rounds half to even, applies the
    // sign and out_min, clamps to 0..255 (a flat job takes its flat value instead)
    // and holds the result in an output register until the consumer takes it.
    mcs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_stretched_pixel (o_stretched_pixel)
    );

endmodule

@@ design/mcs_checker.sv @@
// Port-level checker for masked_contrast_stretch, attached by bind.
// Depends on mcs_pkg for field widths.
module mcs_checker
    import mcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_mode,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [PIX_W-1:0] o_stretched_pixel
);

    localparam int PEND_MAX = QUEUE_DEPTH + 2;
    localparam int PEND_W   = $clog2(PEND_MAX + 1) + 1;

    logic              w_in_take, w_out_take;
    logic [PEND_W-1:0] r_pend;

    assign w_in_take  = i_in_valid & ~o_in_stall & i_mode;
    assign w_out_take = o_out_valid & ~i_out_stall;

    // Stretch transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(w_in_take) - PEND_W'(w_out_take);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_stretched_pixel))
        else $error("stalled result changed or vanished");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("result shown without a pending stretch transaction");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(PEND_MAX))
        else $error("more stretch transactions in flight than storage allows");

endmodule

bind masked_contrast_stretch mcs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mcs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_mode            (i_mode),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_stretched_pixel (o_stretched_pixel)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the masked contrast stretch block.
// It drives the pixel, output and register channels and predicts every stretched level.
// It depends on mcs_pkg and on the masked_contrast_stretch top level.
module tb;
    import mcs_pkg::*;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_STRETCH = 1'b1;
    localparam int   DRAIN_CYCLES = 32;       // a little above the stretch latency
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_ITEMS = 1150;
    localparam int   REPORT_MAX   = 10;

    logic i_clk;
    logic rst_n = 1'b0;

    // Pixel channel, driven by this testbench.
    logic             in_valid  = 1'b0;
    logic             in_mode   = MODE_MEASURE;
    logic [PIX_W-1:0] in_pixel  = '0;
    logic             in_region = 1'b0;
    logic             in_restart = 1'b0;
    logic             o_in_stall;

    // Result channel.
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] o_stretched_pixel;

    // Register write channel.
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OUT_MIN;
    logic [PIX_W-1:0]     cfg_data  = '0;
    logic                 o_cfg_ready;

    masked_contrast_stretch u_top (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (in_mode),
        .i_pixel           (in_pixel),
        .i_in_region       (in_region),
        .i_restart         (in_restart),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_stretched_pixel (o_stretched_pixel),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // Shadow copy of the block's registers and running statistics.
    logic [PIX_W-1:0] cur_out_min    = 8'd0;
    logic [PIX_W-1:0] cur_out_max    = 8'd255;
    logic [PIX_W-1:0] seen_darkest   = PIX_MAX;
    logic [PIX_W-1:0] seen_brightest = PIX_MIN;

    logic [PIX_W-1:0] pending_levels[$];   // stretched levels still to arrive
    int               mismatch_count = 0;
    int               items_sent     = 0;
    int               cycle_count    = 0;
    int               rx_hold        = 0;
    bit               tx_idle_on     = 1'b1;
    bit               rx_idle_on     = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Maps one pixel through the current statistics and output range.
    // The quotient is floored, then rounded half to even, then clamped.
    function automatic logic [PIX_W-1:0] predict_stretch(input logic [PIX_W-1:0] p);
        int lo, hi, num, den, q, r, v;
        lo = int'(seen_darkest);
        hi = int'(seen_brightest);
        if (hi == lo)
            return (int'(p) > lo) ? PIX_MAX : PIX_MIN;
        num = (int'(p) - lo) * (int'(cur_out_max) - int'(cur_out_min));
        den = hi - lo;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        q = num / den;
        r = num - q * den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        if (2 * r > den || (2 * r == den && q[0]))
            q = q + 1;
        v = int'(cur_out_min) + q;
        if (v > 255)
            v = 255;
        if (v < 0)
            v = 0;
        return v[PIX_W-1:0];
    endfunction

    // Sends one pixel transaction and updates the shadow state once it is taken.
    task automatic push_pixel(input logic mode, input logic [PIX_W-1:0] pix,
                              input logic region, input logic restart);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_mode    <= mode;
        in_pixel   <= pix;
        in_region  <= region;
        in_restart <= restart;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
        if (mode == MODE_STRETCH) begin
            pending_levels.insert(pending_levels.size(), predict_stretch(pix));
        end else begin
            if (restart) begin
                seen_darkest   = PIX_MAX;
                seen_brightest = PIX_MIN;
            end
            if (region) begin
                if (pix < seen_darkest)
                    seen_darkest = pix;
                if (pix > seen_brightest)
                    seen_brightest = pix;
            end
        end
    endtask

    // Holds the sender until every stretched level has come back, then lets
    // settle cycles pass so that trailing measure transactions are absorbed too.
    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_OUT_MIN)
            cur_out_min = data;
        else
            cur_out_max = data;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_level(input int lo, input int wid);
        int v;
        v = lo + int'($urandom_range(0, wid));
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    // Nothing measured yet: the span is negative and the map comes out inverted.
    // A pixel outside the region is ignored and must leave the statistics empty.
    task automatic test_empty_region();
        push_pixel(MODE_MEASURE, 8'd42, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd0, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd255, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd128, 1'b0, 1'b0);
    endtask

    // One measured level gives flat statistics; restart and region flags on
    // stretch transactions must have no effect.
    task automatic test_flat_stats();
        push_pixel(MODE_MEASURE, 8'd100, 1'b1, 1'b1);
        push_pixel(MODE_MEASURE, 8'd7, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd99, 1'b1, 1'b1);
        push_pixel(MODE_STRETCH, 8'd100, 1'b1, 1'b0);
        push_pixel(MODE_STRETCH, 8'd101, 1'b0, 1'b1);
    endtask

    task automatic test_full_range();
        push_pixel(MODE_MEASURE, 8'd0, 1'b1, 1'b1);
        push_pixel(MODE_MEASURE, 8'd255, 1'b1, 1'b0);
        push_pixel(MODE_STRETCH, 8'd0, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd255, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd77, 1'b0, 1'b0);
    endtask

    // A span of two with a one-level output range puts 11, 13 and 9 exactly on
    // halves, on both sides of the darkest level; 8 maps to a whole step.
    task automatic test_rounding();
        wait_idle(DRAIN_CYCLES);
        write_reg(CFG_OUT_MIN, 8'd0);
        write_reg(CFG_OUT_MAX, 8'd1);
        push_pixel(MODE_MEASURE, 8'd10, 1'b1, 1'b1);
        push_pixel(MODE_MEASURE, 8'd12, 1'b1, 1'b0);
        push_pixel(MODE_STRETCH, 8'd11, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd13, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd9, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd8, 1'b0, 1'b0);
    endtask

    task automatic test_inverted_range();
        wait_idle(DRAIN_CYCLES);
        write_reg(CFG_OUT_MIN, 8'd255);
        write_reg(CFG_OUT_MAX, 8'd0);
        push_pixel(MODE_STRETCH, 8'd10, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd11, 1'b0, 1'b0);
        push_pixel(MODE_STRETCH, 8'd255, 1'b0, 1'b0);
    endtask

    // Frames of a measure pass followed by a stretch pass, each under a fresh
    // output range. Region width varies from flat to full so that spans of
    // every size occur; a few stray or broken transactions are mixed in.
    task automatic test_random_frames(input int count);
        int target, n_meas, n_str, lo, wid, k, sel;
        logic [PIX_W-1:0] mn, mx;
        target = items_sent + count;
        while (items_sent < target) begin
            wait_idle(DRAIN_CYCLES);
            sel = $urandom_range(0, 5);
            case (sel)
                0: begin
                    mn = 8'd0;
                    mx = 8'd255;
                end
                1: begin
                    mn = 8'd255;
                    mx = 8'd0;
                end
                2: begin
                    mn = PIX_W'($urandom);
                    mx = mn;
                end
                default: begin
                    mn = PIX_W'($urandom);
                    mx = PIX_W'($urandom);
                end
            endcase
            write_reg(CFG_OUT_MIN, mn);
            write_reg(CFG_OUT_MAX, mx);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 3))
                0: wid = 0;
                1: wid = $urandom_range(1, 8);
                2: wid = $urandom_range(9, 64);
                default: wid = 255;
            endcase
            lo = $urandom_range(0, 255);
            n_meas = $urandom_range(1, 16);
            for (k = 0; k < n_meas; k++) begin
                push_pixel(MODE_MEASURE, pick_level(lo, wid),
                           ($urandom_range(0, 7) != 0),
                           (k == 0) || ($urandom_range(0, 31) == 0));
            end

            n_str = $urandom_range(4, 20);
            for (k = 0; k < n_str; k++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    push_pixel(MODE_MEASURE, PIX_W'($urandom), 1'($urandom),
                               1'($urandom));
                else if (sel < 8)
                    push_pixel(MODE_STRETCH, pick_level(lo, wid), 1'($urandom),
                               1'($urandom));
                else
                    push_pixel(MODE_STRETCH, PIX_W'($urandom), 1'($urandom),
                               1'($urandom));
            end
            // Now and then the sender holds off until the output side is empty.
            if ($urandom_range(0, 3) == 0)
                wait_idle(0);
        end
    endtask

    // Result side: takes each stretched level, compares it with the oldest
    // prediction, then stalls for a freshly drawn number of cycles.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid === 1'b1 && !out_stall) begin
                if (pending_levels.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected stretch result %0d", o_stretched_pixel);
                    mismatch_count++;
                end else begin
                    if (o_stretched_pixel !== pending_levels[0]) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("stretched_pixel mismatch: expected %0d, actual %0d",
                                     pending_levels[0], o_stretched_pixel);
                        mismatch_count++;
                    end
                    void'(pending_levels.pop_front());
                end
                rx_hold = rx_idle_on ? $urandom_range(0, 4) : 0;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
        end
        out_stall <= (rx_hold != 0);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_region();
        test_flat_stats();
        test_full_range();
        test_rounding();
        test_inverted_range();
        test_random_frames(RANDOM_ITEMS);

        wait_idle(DRAIN_CYCLES);
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
